/* sv/rscm_pkg.sv */
// Shared types, constants and codes of the ripple/spiral color-mask effect unit.
package rscm_pkg;

   // Default frame capacity; the storage of both tables follows from these.
   localparam int MAX_WIDTH_DEF  = 512;
   localparam int MAX_HEIGHT_DEF = 256;

   // Field and register widths fixed by the interface.
   localparam int OP_W        = 2;
   localparam int SAMPLE_W    = 16;
   localparam int TIDX_W      = 19;
   localparam int TVAL_W      = 8;
   localparam int PIX_W       = 17;
   localparam int CIDX_W      = 15;
   localparam int POS_W       = 10;
   localparam int PHASE_W     = 8;
   localparam int DIR_W       = 4;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int WIDTH_REG_W = 10;
   localparam int HEIGHT_REG_W = 9;
   localparam int XSTART_W    = 9;
   localparam int YSTART_W    = 8;

   // Reset values.
   localparam logic [SAMPLE_W-1:0] MASK_RESET   = 16'hFFFF;
   localparam int                  WIDTH_RESET  = 320;
   localparam int                  HEIGHT_RESET = 240;
   // Red moves toward negative on both axes, blue toward positive.
   localparam logic [DIR_W-1:0]    DIR_RESET    = 4'b0011;

   // Per-frame phase step.
   localparam logic [PHASE_W-1:0] PHASE_STEP = 8'd8;

   // Masks selected by the sign bit of a table byte.
   localparam logic [SAMPLE_W-1:0] LUMA_MASK_ON   = 16'h7F80;
   localparam logic [SAMPLE_W-1:0] LUMA_MASK_OFF  = 16'h0000;
   localparam logic [SAMPLE_W-1:0] CHROMA_MASK_ON  = 16'h7F00;
   localparam logic [SAMPLE_W-1:0] CHROMA_MASK_OFF = 16'h8000;

   // Depths of the queues between the parts.
   localparam int QUEUE_DEPTH = 4;
   localparam int OUT_DEPTH   = 4;

   typedef enum logic [OP_W-1:0] {
      OP_PIXEL  = 2'd0,
      OP_RIPPLE = 2'd1,
      OP_SPIRAL = 2'd2
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PIXEL_MASK   = 3'd0,
      CSR_FRAME_WIDTH  = 3'd1,
      CSR_FRAME_HEIGHT = 3'd2,
      CSR_RED_START_X  = 3'd3,
      CSR_RED_START_Y  = 3'd4,
      CSR_BLUE_START_X = 3'd5,
      CSR_BLUE_START_Y = 3'd6
   } csr_index_type;

   // One classified item on its way from the front to the back.
   typedef struct packed {
      op_type                op;
      logic [SAMPLE_W-1:0]   sample;
      logic [TIDX_W-1:0]     table_index;
      logic [TVAL_W-1:0]     table_value;
      logic [PIX_W-1:0]      pixel_index;
      logic [PHASE_W-1:0]    phase;
      logic                  last;
   } item_type;

   // One finished result.
   typedef struct packed {
      logic [PIX_W-1:0]    pixel_index;
      logic [SAMPLE_W-1:0] luma_out;
      logic [CIDX_W-1:0]   chroma_index;
      logic [SAMPLE_W-1:0] chroma_u_out;
      logic [SAMPLE_W-1:0] chroma_v_out;
      logic                frame_end;
   } result_type;

endpackage

/* sv/rscm_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
module rscm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/rscm_fifo.sv */
// Small first-in first-out queue with an occupancy count.
module rscm_fifo import rscm_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           push_data,
   input  logic                       pop,
   output logic [WIDTH-1:0]           pop_data,
   output logic                       empty,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] ptr);
      return (ptr == PW'(DEPTH - 1)) ? '0 : ptr + PW'(1);
   endfunction

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = store_ff[rd_ptr_ff];
   assign empty    = (count_ff == '0);
   assign count    = count_ff;

endmodule

/* sv/rscm_front.sv */
// Front part: configuration registers, raster counters, motion state and address generation.
module rscm_front import rscm_pkg::*; #(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          req_push,
   output logic                                          req_full,
   input  logic [OP_W-1:0]                               req_operation,
   input  logic [SAMPLE_W-1:0]                           req_luma_sample,
   input  logic [TIDX_W-1:0]                             req_table_index,
   input  logic [TVAL_W-1:0]                             req_table_value,
   input  logic                                          csr_wr_en,
   input  logic [CSR_IDX_W-1:0]                          csr_index,
   input  logic [CSR_DATA_W-1:0]                         csr_wr_data,
   input  logic [$clog2(QUEUE_DEPTH+1)-1:0]              queue_count,
   output logic [SAMPLE_W-1:0]                           pixel_mask,
   output logic                                          queue_push,
   output item_type                                      queue_item,
   output logic [$clog2(4*MAX_WIDTH*MAX_HEIGHT)-1:0]     red_addr,
   output logic [$clog2(4*MAX_WIDTH*MAX_HEIGHT)-1:0]     blue_addr,
   output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]       spiral_addr
);

   localparam int RAW = $clog2(4 * MAX_WIDTH * MAX_HEIGHT);
   localparam int SAW = $clog2(MAX_WIDTH * MAX_HEIGHT);
   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int RW  = $clog2(MAX_HEIGHT);
   localparam int WW  = $clog2(MAX_WIDTH + 1);
   localparam int HW  = $clog2(MAX_HEIGHT + 1);
   localparam int YW  = ((POS_W > RW) ? POS_W : RW) + 1;
   localparam int RPW = YW + WW + 1;
   localparam int PPW = RW + WW;
   localparam int PXW = PIX_W + SAW;
   localparam int QCW = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [POS_W-1:0] pos;
      logic             flip;
   } bounce_type;

   function automatic logic [WW-1:0] sat_width(input int value);
      int v;
      v = value;
      if (v < 2) v = 2;
      if (v > MAX_WIDTH) v = MAX_WIDTH;
      return WW'(v);
   endfunction

   function automatic logic [HW-1:0] sat_height(input int value);
      int v;
      v = value;
      if (v < 2) v = 2;
      if (v > MAX_HEIGHT) v = MAX_HEIGHT;
      return HW'(v);
   endfunction

   // Step two places along one axis, turning around first if the step would leave
   // the range from zero up to one below the limit.
   function automatic bounce_type bounce(input logic [POS_W-1:0] pos, input logic dir,
                                         input int limit);
      bounce_type res;
      int         s;
      s = int'(pos) + (dir ? -2 : 2);
      res.flip = 1'b0;
      if (s < 0 || s >= limit) begin
         res.flip = 1'b1;
         s = int'(pos) + (dir ? 2 : -2);
      end
      res.pos = POS_W'(s);
      return res;
   endfunction

   // Configuration and motion state.
   logic [SAMPLE_W-1:0] mask_ff, mask_in;
   logic [WW-1:0]       width_ff, width_in;
   logic [HW-1:0]       height_ff, height_in;
   logic [PHASE_W-1:0]  phase_ff, phase_in;
   logic [POS_W-1:0]    red_x_ff, red_x_in, red_y_ff, red_y_in;
   logic [POS_W-1:0]    blue_x_ff, blue_x_in, blue_y_ff, blue_y_in;
   logic [DIR_W-1:0]    dir_ff, dir_in;
   logic [CW-1:0]       col_ff, col_in;
   logic [RW-1:0]       row_ff, row_in;

   // Address stage.
   logic                f1_valid_ff, f1_valid_in;
   item_type            f1_item_ff, f1_item_in;
   logic [SAW-1:0]      f1_pix_prod_ff, f1_pix_prod_in;
   logic [RAW-1:0]      f1_red_prod_ff, f1_red_prod_in;
   logic [RAW-1:0]      f1_blue_prod_ff, f1_blue_prod_in;
   logic [CW-1:0]       f1_col_ff;
   logic [POS_W-1:0]    f1_red_x_ff, f1_blue_x_ff;

   logic                accept, is_pixel, col_last, row_last, frame_last;
   logic [QCW:0]        occupancy;
   logic [YW-1:0]       red_row, blue_row;
   logic [WW:0]         width2;
   logic [RPW-1:0]      red_prod_full, blue_prod_full;
   logic [PPW-1:0]      pix_prod_full;
   logic [SAW-1:0]      pix;
   logic [PXW-1:0]      pix_ext;
   bounce_type          red_bx, red_by, blue_bx, blue_by;

   assign occupancy = (QCW + 1)'(queue_count) + (QCW + 1)'(f1_valid_ff);
   assign req_full  = (occupancy >= (QCW + 1)'(QUEUE_DEPTH));
   assign accept    = req_push && !req_full;
   assign is_pixel  = (op_type'(req_operation) == OP_PIXEL);
   assign col_last  = ((WW'(col_ff) + WW'(1)) == width_ff);
   assign row_last  = ((HW'(row_ff) + HW'(1)) == height_ff);
   assign frame_last = col_last && row_last;

   assign red_bx  = bounce(red_x_ff,  dir_ff[0], int'(width_ff));
   assign red_by  = bounce(red_y_ff,  dir_ff[1], int'(height_ff));
   assign blue_bx = bounce(blue_x_ff, dir_ff[2], int'(width_ff));
   assign blue_by = bounce(blue_y_ff, dir_ff[3], int'(height_ff));

   // Row products; the column terms are added in the next stage.
   assign width2         = {width_ff, 1'b0};
   assign red_row        = YW'(red_y_ff) + YW'(row_ff);
   assign blue_row       = YW'(blue_y_ff) + YW'(row_ff);
   assign red_prod_full  = red_row * width2;
   assign blue_prod_full = blue_row * width2;
   assign pix_prod_full  = row_ff * width_ff;

   always_comb begin
      mask_in   = mask_ff;
      width_in  = width_ff;
      height_in = height_ff;
      phase_in  = phase_ff;
      red_x_in  = red_x_ff;
      red_y_in  = red_y_ff;
      blue_x_in = blue_x_ff;
      blue_y_in = blue_y_ff;
      dir_in    = dir_ff;
      col_in    = col_ff;
      row_in    = row_ff;

      if (accept && is_pixel) begin
         if (col_last) begin
            col_in = '0;
            row_in = row_last ? '0 : row_ff + RW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
         if (frame_last) begin
            phase_in  = phase_ff - PHASE_STEP;
            red_x_in  = red_bx.pos;
            red_y_in  = red_by.pos;
            blue_x_in = blue_bx.pos;
            blue_y_in = blue_by.pos;
            dir_in    = dir_ff ^ {blue_by.flip, blue_bx.flip, red_by.flip, red_bx.flip};
         end
      end

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_PIXEL_MASK: begin
               mask_in = csr_wr_data;
            end
            CSR_FRAME_WIDTH: begin
               width_in = sat_width(int'(csr_wr_data[WIDTH_REG_W-1:0]));
               col_in   = '0;
               row_in   = '0;
            end
            CSR_FRAME_HEIGHT: begin
               height_in = sat_height(int'(csr_wr_data[HEIGHT_REG_W-1:0]));
               col_in    = '0;
               row_in    = '0;
            end
            CSR_RED_START_X: begin
               red_x_in = POS_W'(csr_wr_data[XSTART_W-1:0]);
            end
            CSR_RED_START_Y: begin
               red_y_in = POS_W'(csr_wr_data[YSTART_W-1:0]);
            end
            CSR_BLUE_START_X: begin
               blue_x_in = POS_W'(csr_wr_data[XSTART_W-1:0]);
            end
            CSR_BLUE_START_Y: begin
               blue_y_in = POS_W'(csr_wr_data[YSTART_W-1:0]);
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      f1_valid_in            = accept;
      f1_item_in.op          = op_type'(req_operation);
      f1_item_in.sample      = req_luma_sample;
      f1_item_in.table_index = req_table_index;
      f1_item_in.table_value = req_table_value;
      f1_item_in.pixel_index = '0;
      f1_item_in.phase       = phase_ff;
      f1_item_in.last        = is_pixel && frame_last;
      f1_pix_prod_in         = SAW'(pix_prod_full);
      f1_red_prod_in         = RAW'(red_prod_full);
      f1_blue_prod_in        = RAW'(blue_prod_full);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff     <= MASK_RESET;
         width_ff    <= sat_width(WIDTH_RESET);
         height_ff   <= sat_height(HEIGHT_RESET);
         phase_ff    <= '0;
         red_x_ff    <= '0;
         red_y_ff    <= '0;
         blue_x_ff   <= '0;
         blue_y_ff   <= '0;
         dir_ff      <= DIR_RESET;
         col_ff      <= '0;
         row_ff      <= '0;
         f1_valid_ff <= 1'b0;
      end else begin
         mask_ff     <= mask_in;
         width_ff    <= width_in;
         height_ff   <= height_in;
         phase_ff    <= phase_in;
         red_x_ff    <= red_x_in;
         red_y_ff    <= red_y_in;
         blue_x_ff   <= blue_x_in;
         blue_y_ff   <= blue_y_in;
         dir_ff      <= dir_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         f1_valid_ff <= f1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         f1_item_ff      <= f1_item_in;
         f1_pix_prod_ff  <= f1_pix_prod_in;
         f1_red_prod_ff  <= f1_red_prod_in;
         f1_blue_prod_ff <= f1_blue_prod_in;
         f1_col_ff       <= col_ff;
         f1_red_x_ff     <= red_x_ff;
         f1_blue_x_ff    <= blue_x_ff;
      end
   end

   // Column terms complete the addresses; the ripple reads wrap with the table.
   assign pix     = f1_pix_prod_ff + SAW'(f1_col_ff);
   assign pix_ext = PXW'(pix);

   always_comb begin
      queue_item             = f1_item_ff;
      queue_item.pixel_index = pix_ext[PIX_W-1:0];
   end

   assign queue_push  = f1_valid_ff;
   assign spiral_addr = pix;
   assign red_addr    = f1_red_prod_ff + RAW'(f1_red_x_ff) + RAW'(f1_col_ff);
   assign blue_addr   = f1_blue_prod_ff + RAW'(f1_blue_x_ff) + RAW'(f1_col_ff);
   assign pixel_mask  = mask_ff;

endmodule

/* sv/rscm_back.sv */
// Back part: table writes and reads, byte tests and output masking.
module rscm_back import rscm_pkg::*; #(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      queue_empty,
   output logic                                      queue_pop,
   input  item_type                                  queue_item,
   input  logic [$clog2(4*MAX_WIDTH*MAX_HEIGHT)-1:0] red_addr,
   input  logic [$clog2(4*MAX_WIDTH*MAX_HEIGHT)-1:0] blue_addr,
   input  logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]   spiral_addr,
   input  logic [SAMPLE_W-1:0]                       pixel_mask,
   input  logic [$clog2(OUT_DEPTH+1)-1:0]            out_count,
   output logic                                      out_push,
   output result_type                                out_result
);

   localparam int RAW = $clog2(4 * MAX_WIDTH * MAX_HEIGHT);
   localparam int SAW = $clog2(MAX_WIDTH * MAX_HEIGHT);
   localparam int IRW = TIDX_W + RAW;
   localparam int ISW = TIDX_W + SAW;
   localparam int OCW = $clog2(OUT_DEPTH + 1);

   logic                b1_valid_ff, b1_valid_in;
   logic [SAMPLE_W-1:0] b1_sample_ff;
   logic [PIX_W-1:0]    b1_pix_ff;
   logic [PHASE_W-1:0]  b1_phase_ff;
   logic                b1_last_ff;

   logic [OCW:0]        occupancy;
   logic [IRW-1:0]      ripple_index;
   logic [ISW-1:0]      spiral_index;
   logic                ripple_in_range, spiral_in_range;
   logic                ripple_we, spiral_we, pixel_rd;
   logic [TVAL_W-1:0]   red_byte, blue_byte, spiral_byte;
   logic [TVAL_W-1:0]   luma_byte, u_byte, v_byte;
   logic [SAMPLE_W-1:0] luma_mask, u_mask, v_mask, sample_masked;

   // Space in the output queue is reserved for every item in the read stage.
   assign occupancy = (OCW + 1)'(out_count) + (OCW + 1)'(b1_valid_ff);
   assign queue_pop = !queue_empty && (occupancy < (OCW + 1)'(OUT_DEPTH));

   assign ripple_index    = IRW'(queue_item.table_index);
   assign spiral_index    = ISW'(queue_item.table_index);
   assign ripple_in_range = ((ripple_index >> RAW) == '0);
   assign spiral_in_range = ((spiral_index >> SAW) == '0);

   assign ripple_we = queue_pop && (queue_item.op == OP_RIPPLE) && ripple_in_range;
   assign spiral_we = queue_pop && (queue_item.op == OP_SPIRAL) && spiral_in_range;
   assign pixel_rd  = queue_pop && (queue_item.op == OP_PIXEL);

   // The ripple table is kept twice so the red and blue windows read in the same cycle.
   rscm_ram #(
      .WIDTH (TVAL_W),
      .DEPTH (2 ** RAW)
   ) u_ripple_red (
      .clock   (clock),
      .wr_en   (ripple_we),
      .wr_addr (ripple_index[RAW-1:0]),
      .wr_data (queue_item.table_value),
      .rd_en   (pixel_rd),
      .rd_addr (red_addr),
      .rd_data (red_byte)
   );

   rscm_ram #(
      .WIDTH (TVAL_W),
      .DEPTH (2 ** RAW)
   ) u_ripple_blue (
      .clock   (clock),
      .wr_en   (ripple_we),
      .wr_addr (ripple_index[RAW-1:0]),
      .wr_data (queue_item.table_value),
      .rd_en   (pixel_rd),
      .rd_addr (blue_addr),
      .rd_data (blue_byte)
   );

   rscm_ram #(
      .WIDTH (TVAL_W),
      .DEPTH (2 ** SAW)
   ) u_spiral (
      .clock   (clock),
      .wr_en   (spiral_we),
      .wr_addr (spiral_index[SAW-1:0]),
      .wr_data (queue_item.table_value),
      .rd_en   (pixel_rd),
      .rd_addr (spiral_addr),
      .rd_data (spiral_byte)
   );

   assign b1_valid_in = pixel_rd;

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
      end else begin
         b1_valid_ff <= b1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pixel_rd) begin
         b1_sample_ff <= queue_item.sample;
         b1_pix_ff    <= queue_item.pixel_index;
         b1_phase_ff  <= queue_item.phase;
         b1_last_ff   <= queue_item.last;
      end
   end

   // Phase offsets: twice the phase for luma, three times for U, minus the phase for V.
   assign luma_byte = red_byte + {b1_phase_ff[PHASE_W-2:0], 1'b0};
   assign u_byte    = spiral_byte + b1_phase_ff + {b1_phase_ff[PHASE_W-2:0], 1'b0};
   assign v_byte    = blue_byte - b1_phase_ff;

   assign luma_mask = luma_byte[TVAL_W-1] ? LUMA_MASK_ON : LUMA_MASK_OFF;
   assign u_mask    = u_byte[TVAL_W-1] ? CHROMA_MASK_ON : CHROMA_MASK_OFF;
   assign v_mask    = v_byte[TVAL_W-1] ? CHROMA_MASK_ON : CHROMA_MASK_OFF;

   assign sample_masked = b1_sample_ff & pixel_mask;

   always_comb begin
      out_result.pixel_index  = b1_pix_ff;
      out_result.luma_out     = sample_masked & luma_mask;
      out_result.chroma_index = b1_pix_ff[PIX_W-1:PIX_W-CIDX_W];
      out_result.chroma_u_out = sample_masked & u_mask;
      out_result.chroma_v_out = sample_masked & v_mask;
      out_result.frame_end    = b1_last_ff;
   end

   assign out_push = b1_valid_ff;

endmodule

/* sv/ripple_spiral_color_mask_effect_unit.sv */
// Top level of the ripple/spiral color-mask effect unit.
// A pixel goes through the front's address stage, the item queue, the table read stage
// and the result queue to the result ports; table loads give no result. Throughput: one
// item per clock while req_full is low, set by the single read port of each table copy.
// Reset is synchronous and active high; the tables are not cleared by it and read
// undefined until loaded. Registers, motion state and both queues reset at once.
module ripple_spiral_color_mask_effect_unit import rscm_pkg::*; #(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   // Input queue side.
   input  logic                        req_push,
   output logic                        req_full,
   input  logic [OP_W-1:0]             req_operation,
   input  logic signed [SAMPLE_W-1:0]  req_luma_sample,
   input  logic [TIDX_W-1:0]           req_table_index,
   input  logic [TVAL_W-1:0]           req_table_value,
   // Result queue side.
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output logic [PIX_W-1:0]            rsp_pixel_index,
   output logic signed [SAMPLE_W-1:0]  rsp_luma_out,
   output logic [CIDX_W-1:0]           rsp_chroma_index,
   output logic signed [SAMPLE_W-1:0]  rsp_chroma_u_out,
   output logic signed [SAMPLE_W-1:0]  rsp_chroma_v_out,
   output logic                        rsp_frame_end,
   // Configuration write port.
   input  logic                        csr_wr_en,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_wr_data
);

   // Ripple table spans twice the frame on each axis; the spiral table one frame.
   localparam int RAW = $clog2(4 * MAX_WIDTH * MAX_HEIGHT);
   localparam int SAW = $clog2(MAX_WIDTH * MAX_HEIGHT);
   localparam int IW  = $bits(item_type);
   localparam int QW  = IW + 2 * RAW + SAW;
   localparam int RSW = $bits(result_type);
   localparam int QCW = $clog2(QUEUE_DEPTH + 1);
   localparam int OCW = $clog2(OUT_DEPTH + 1);

   logic [SAMPLE_W-1:0] pixel_mask;

   // Front to queue.
   logic           f_push;
   item_type       f_item;
   logic [RAW-1:0] f_red_addr, f_blue_addr;
   logic [SAW-1:0] f_spiral_addr;
   logic [QW-1:0]  q_push_data, q_pop_data;
   logic           q_pop, q_empty;
   logic [QCW-1:0] q_count;

   // Queue head to back.
   item_type       h_item;
   logic [RAW-1:0] h_red_addr, h_blue_addr;
   logic [SAW-1:0] h_spiral_addr;

   // Back to result queue.
   logic           o_push;
   result_type     o_result, o_head;
   logic [RSW-1:0] o_pop_data;
   logic [OCW-1:0] o_count;
   logic           o_pop;

   // The front counts raster position and moves the windows; every accepted item gets
   // its table addresses here, so the back only has to write, read, test and mask.
   rscm_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_operation   (req_operation),
      .req_luma_sample (req_luma_sample),
      .req_table_index (req_table_index),
      .req_table_value (req_table_value),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data),
      .queue_count     (q_count),
      .pixel_mask      (pixel_mask),
      .queue_push      (f_push),
      .queue_item      (f_item),
      .red_addr        (f_red_addr),
      .blue_addr       (f_blue_addr),
      .spiral_addr     (f_spiral_addr)
   );

   // The item queue decouples the two parts. The front reserves a slot for the item in
   // its address stage, so a push never meets a full queue.
   assign q_push_data = {f_red_addr, f_blue_addr, f_spiral_addr, f_item};

   rscm_fifo #(
      .WIDTH (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_item_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .empty     (q_empty),
      .count     (q_count)
   );

   assign h_item        = q_pop_data[IW-1:0];
   assign h_spiral_addr = q_pop_data[IW+SAW-1:IW];
   assign h_blue_addr   = q_pop_data[IW+SAW+RAW-1:IW+SAW];
   assign h_red_addr    = q_pop_data[QW-1:IW+SAW+RAW];

   // Loads and reads are issued in item order, so a pixel always sees every in-range load
   // that was transferred ahead of it.
   rscm_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (q_empty),
      .queue_pop   (q_pop),
      .queue_item  (h_item),
      .red_addr    (h_red_addr),
      .blue_addr   (h_blue_addr),
      .spiral_addr (h_spiral_addr),
      .pixel_mask  (pixel_mask),
      .out_count   (o_count),
      .out_push    (o_push),
      .out_result  (o_result)
   );

   // The result queue holds finished results while the consumer stalls; the back
   // reserves a slot before it reads the tables.
   assign o_pop = rsp_pop && !rsp_empty;

   rscm_fifo #(
      .WIDTH (RSW),
      .DEPTH (OUT_DEPTH)
   ) u_result_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (o_push),
      .push_data (o_result),
      .pop       (o_pop),
      .pop_data  (o_pop_data),
      .empty     (rsp_empty),
      .count     (o_count)
   );

   assign o_head           = o_pop_data;
   assign rsp_pixel_index  = o_head.pixel_index;
   assign rsp_luma_out     = $signed(o_head.luma_out);
   assign rsp_chroma_index = o_head.chroma_index;
   assign rsp_chroma_u_out = $signed(o_head.chroma_u_out);
   assign rsp_chroma_v_out = $signed(o_head.chroma_v_out);
   assign rsp_frame_end    = o_head.frame_end;

endmodule
